>>> hw/rtl/cpio_pkg.sv
package cpio_pkg;

    localparam int unsigned HDR_LEN     = 110;
    localparam int unsigned MAGIC_LEN   = 6;
    localparam int unsigned FSIZE_OFS   = 54;
    localparam int unsigned NSIZE_OFS   = 94;
    localparam int unsigned HEX_DIGITS  = 8;
    localparam int unsigned TRAILER_LEN = 11;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned HCNT_W = $clog2(HDR_LEN + 1);
    localparam int unsigned NIDX_W = $clog2(TRAILER_LEN + 1);
    localparam int unsigned MIDX_W = $clog2(MAGIC_LEN);
    localparam int unsigned SIZE_W = 32;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_HEADER  = 3'd0;
    localparam t_kind K_NAME    = 3'd1;
    localparam t_kind K_NAMEPAD = 3'd2;
    localparam t_kind K_DATA    = 3'd3;
    localparam t_kind K_DATAPAD = 3'd4;
    localparam t_kind K_END     = 3'd5;
    localparam t_kind K_ERROR   = 3'd6;

    localparam logic [7:0] MAGIC_CHARS [MAGIC_LEN] = '{
        8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31
    };

    localparam logic [7:0] TRAILER_CHARS [TRAILER_LEN] = '{
        8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21, 8'h00
    };

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] b);
        t_hex_digit d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            d.val = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            d.val = 4'(b[2:0] + 3'd1) + 4'd8;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/cpio_newc_stream_parser.sv
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless output stalls; all per-byte work
// is counter, compare and decrement logic between the state and result
// registers. A held result does not block intake while it is being taken.
// Reset (synchronous, active low) returns to the header phase of the first
// entry with all sizes and counters cleared and no result pending.
module cpio_newc_stream_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_archive_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_byte_kind,
    output logic [7:0]                 o_data_byte,
    output logic [31:0]                o_entry_size,
    output logic [31:0]                o_name_length,
    output logic                       o_entry_done,
    output logic                       o_is_trailer
);

    localparam int unsigned HCNT_W = cpio_pkg::HCNT_W;

    cpio_pkg::t_kind                     r_phase, n_phase;
    logic [cpio_pkg::HCNT_W-1:0]         r_hdr_cnt, n_hdr_cnt;
    logic [cpio_pkg::SIZE_W-1:0]         r_hex_acc, n_hex_acc;
    logic                                r_hex_stop, n_hex_stop;
    logic [cpio_pkg::SIZE_W-1:0]         r_size, n_size;
    logic [cpio_pkg::SIZE_W-1:0]         r_nsize, n_nsize;
    logic [cpio_pkg::SIZE_W-1:0]         r_remain, n_remain;
    logic                                r_trl_match, n_trl_match;
    logic [cpio_pkg::NIDX_W-1:0]         r_name_idx, n_name_idx;

    logic                                r_out_valid;
    cpio_pkg::t_kind                     r_out_kind, n_out_kind;
    logic [7:0]                          r_out_byte;
    logic [cpio_pkg::SIZE_W-1:0]         r_out_fsize;
    logic [cpio_pkg::SIZE_W-1:0]         r_out_nsize;
    logic                                r_out_done, n_out_done;
    logic                                r_out_trl;

    logic                                in_acc;
    logic                                do_adv;
    cpio_pkg::t_kind                     adv_from;
    logic [1:0]                          npad_len;
    logic [1:0]                          dpad_len;
    cpio_pkg::t_hex_digit                dig;
    logic                                in_fs;
    logic                                in_ns;
    logic                                hex_first;
    logic [cpio_pkg::SIZE_W-1:0]         dec_remain;

    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    assign npad_len   = 2'd0 - (r_nsize[1:0] + 2'd2);
    assign dpad_len   = 2'd0 - r_size[1:0];
    assign dig        = cpio_pkg::hex_decode(i_archive_byte);
    assign dec_remain = r_remain - 32'd1;

    assign in_fs = (r_hdr_cnt >= HCNT_W'(cpio_pkg::FSIZE_OFS))
                && (r_hdr_cnt <  HCNT_W'(cpio_pkg::FSIZE_OFS + cpio_pkg::HEX_DIGITS));
    assign in_ns = (r_hdr_cnt >= HCNT_W'(cpio_pkg::NSIZE_OFS))
                && (r_hdr_cnt <  HCNT_W'(cpio_pkg::NSIZE_OFS + cpio_pkg::HEX_DIGITS));
    assign hex_first = (r_hdr_cnt == HCNT_W'(cpio_pkg::FSIZE_OFS))
                    || (r_hdr_cnt == HCNT_W'(cpio_pkg::NSIZE_OFS));

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hex_acc   = r_hex_acc;
        n_hex_stop  = r_hex_stop;
        n_size      = r_size;
        n_nsize     = r_nsize;
        n_remain    = r_remain;
        n_trl_match = r_trl_match;
        n_name_idx  = r_name_idx;
        n_out_kind  = r_phase;
        n_out_done  = 1'b0;
        do_adv      = 1'b0;
        adv_from    = r_phase;

        case (r_phase)
            cpio_pkg::K_HEADER: begin
                if (r_hdr_cnt < HCNT_W'(cpio_pkg::MAGIC_LEN) &&
                    i_archive_byte !=
                        cpio_pkg::MAGIC_CHARS[r_hdr_cnt[cpio_pkg::MIDX_W-1:0]]) begin
                    n_phase    = cpio_pkg::K_ERROR;
                    n_out_kind = cpio_pkg::K_ERROR;
                end else begin
                    if (in_fs || in_ns) begin
                        if (hex_first) begin
                            n_hex_acc  = '0;
                            n_hex_stop = 1'b0;
                        end
                        if (!n_hex_stop) begin
                            if (dig.ok) begin
                                n_hex_acc = {n_hex_acc[cpio_pkg::SIZE_W-5:0], dig.val};
                            end else begin
                                n_hex_stop = 1'b1;
                            end
                        end
                        // latch the value on the last digit position
                        if (r_hdr_cnt ==
                            HCNT_W'(cpio_pkg::FSIZE_OFS + cpio_pkg::HEX_DIGITS - 1)) begin
                            n_size = n_hex_acc;
                        end
                        if (r_hdr_cnt ==
                            HCNT_W'(cpio_pkg::NSIZE_OFS + cpio_pkg::HEX_DIGITS - 1)) begin
                            n_nsize = n_hex_acc;
                        end
                    end
                    n_hdr_cnt = r_hdr_cnt + HCNT_W'(1);
                    if (n_hdr_cnt >= HCNT_W'(cpio_pkg::HDR_LEN)) begin
                        do_adv = 1'b1;
                    end
                end
            end
            cpio_pkg::K_NAME: begin
                if (r_name_idx < cpio_pkg::NIDX_W'(cpio_pkg::TRAILER_LEN)) begin
                    if (i_archive_byte != cpio_pkg::TRAILER_CHARS[r_name_idx]) begin
                        n_trl_match = 1'b0;
                    end
                    n_name_idx = r_name_idx + cpio_pkg::NIDX_W'(1);
                end
                n_remain = dec_remain;
                do_adv   = (dec_remain == '0);
            end
            cpio_pkg::K_NAMEPAD, cpio_pkg::K_DATA, cpio_pkg::K_DATAPAD: begin
                n_remain = dec_remain;
                do_adv   = (dec_remain == '0);
            end
            cpio_pkg::K_END: begin
            end
            default: begin
                n_phase    = cpio_pkg::K_ERROR;
                n_out_kind = cpio_pkg::K_ERROR;
            end
        endcase

        // skip empty segments; close the entry when none is left
        if (do_adv) begin
            n_out_done = 1'b0;
            if (adv_from < cpio_pkg::K_NAME && r_nsize != '0) begin
                n_phase  = cpio_pkg::K_NAME;
                n_remain = r_nsize;
            end else if (adv_from < cpio_pkg::K_NAMEPAD && npad_len != 2'd0) begin
                n_phase  = cpio_pkg::K_NAMEPAD;
                n_remain = {30'd0, npad_len};
            end else if (adv_from < cpio_pkg::K_DATA && r_size != '0) begin
                n_phase  = cpio_pkg::K_DATA;
                n_remain = r_size;
            end else if (adv_from < cpio_pkg::K_DATAPAD && dpad_len != 2'd0) begin
                n_phase  = cpio_pkg::K_DATAPAD;
                n_remain = {30'd0, dpad_len};
            end else begin
                n_out_done = 1'b1;
                n_remain   = '0;
                if (n_trl_match &&
                    n_name_idx == cpio_pkg::NIDX_W'(cpio_pkg::TRAILER_LEN)) begin
                    n_phase = cpio_pkg::K_END;
                end else begin
                    n_phase     = cpio_pkg::K_HEADER;
                    n_hdr_cnt   = '0;
                    n_trl_match = 1'b1;
                    n_name_idx  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cpio_pkg::K_HEADER;
            r_hdr_cnt   <= '0;
            r_hex_acc   <= '0;
            r_hex_stop  <= 1'b0;
            r_size      <= '0;
            r_nsize     <= '0;
            r_remain    <= '0;
            r_trl_match <= 1'b1;
            r_name_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_hex_acc   <= n_hex_acc;
                r_hex_stop  <= n_hex_stop;
                r_size      <= n_size;
                r_nsize     <= n_nsize;
                r_remain    <= n_remain;
                r_trl_match <= n_trl_match;
                r_name_idx  <= n_name_idx;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_kind  <= n_out_kind;
            r_out_byte  <= i_archive_byte;
            r_out_fsize <= n_size;
            r_out_nsize <= n_nsize;
            r_out_done  <= n_out_done;
            r_out_trl   <= n_trl_match &&
                           (n_name_idx == cpio_pkg::NIDX_W'(cpio_pkg::TRAILER_LEN));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_kind   = r_out_kind;
    assign o_data_byte   = r_out_byte;
    assign o_entry_size  = r_out_fsize;
    assign o_name_length = r_out_nsize;
    assign o_entry_done  = r_out_done;
    assign o_is_trailer  = r_out_trl;

`ifndef SYNTHESIS
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cpio_pkg::K_ERROR |=> r_phase == cpio_pkg::K_ERROR)
        else $error("error phase left without reset");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cpio_pkg::K_END |=> r_phase == cpio_pkg::K_END)
        else $error("end phase left without reset");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_done |->
            o_byte_kind != cpio_pkg::K_END && o_byte_kind != cpio_pkg::K_ERROR)
        else $error("entry end flagged outside an entry");

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cpio_pkg::K_HEADER |-> r_hdr_cnt < HCNT_W'(cpio_pkg::HDR_LEN))
        else $error("header counter ran past header length");

    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cpio_pkg::K_NAME || r_phase == cpio_pkg::K_NAMEPAD ||
         r_phase == cpio_pkg::K_DATA || r_phase == cpio_pkg::K_DATAPAD) |->
            r_remain != '0)
        else $error("segment entered with nothing remaining");
`endif

endmodule

>>> test/cpio_newc_parse_checker.sv
module cpio_newc_parse_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_out_kind,
    input  logic [7:0]  i_out_data,
    input  logic [31:0] i_out_fsize,
    input  logic [31:0] i_out_nlen,
    input  logic        i_out_done,
    input  logic        i_out_trailer,
    output int          o_pending,
    output int          o_mismatches
);

    typedef struct packed {
        cpio_pkg::t_kind kind;
        logic [7:0]      data;
        logic [31:0]     fsize;
        logic [31:0]     nlen;
        logic            done;
        logic            trailer;
    } t_byte_class;

    t_byte_class classified_q[$];
    t_byte_class want_r;
    t_byte_class new_r;
    int          n_results;

    // Parser state as the stream has been seen so far
    cpio_pkg::t_kind seg;
    logic [6:0]      hdr_pos;
    logic [31:0]     hex_acc;
    logic            hex_halt;
    logic [31:0]     fsize_q;
    logic [31:0]     nsize_q;
    logic [31:0]     left_in_seg;
    logic            trl_ok;
    logic [3:0]      trl_idx;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        n_results    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s is %0h, expected %0h",
                 n_results, what, got, want);
        o_mismatches++;
    endtask

    function automatic logic trailer_hit();
        return trl_ok && (trl_idx == cpio_pkg::TRAILER_LEN);
    endfunction

    function automatic logic [31:0] seg_len(input cpio_pkg::t_kind s);
        case (s)
            cpio_pkg::K_NAME:    return nsize_q;
            cpio_pkg::K_NAMEPAD: return (32'd4 - ((cpio_pkg::HDR_LEN + nsize_q) & 32'd3)) & 32'd3;
            cpio_pkg::K_DATA:    return fsize_q;
            default:             return (32'd4 - (fsize_q & 32'd3)) & 32'd3;
        endcase
    endfunction

    // Move to the next non-empty segment, or close the entry.
    task automatic close_segment(input cpio_pkg::t_kind from, output logic ended);
        int          k;
        logic [31:0] n;
        ended = 1'b1;
        for (k = int'(from) + 1; k <= int'(cpio_pkg::K_DATAPAD); k++) begin
            if (ended) begin
                n = seg_len(cpio_pkg::t_kind'(k));
                if (n != 0) begin
                    seg         = cpio_pkg::t_kind'(k);
                    left_in_seg = n;
                    ended       = 1'b0;
                end
            end
        end
        if (ended) begin
            if (trailer_hit()) begin
                seg = cpio_pkg::K_END;
            end else begin
                seg     = cpio_pkg::K_HEADER;
                hdr_pos = '0;
                trl_ok  = 1'b1;
                trl_idx = '0;
            end
            left_in_seg = '0;
        end
    endtask

    task automatic take_hex_digit(input logic [7:0] b, input int pos);
        if (pos == 0) begin
            hex_acc  = '0;
            hex_halt = 1'b0;
        end
        if (!hex_halt) begin
            if (b >= 8'h30 && b <= 8'h39)
                hex_acc = {hex_acc[27:0], 4'(b - 8'h30)};
            else if (b >= 8'h61 && b <= 8'h66)
                hex_acc = {hex_acc[27:0], 4'(b - 8'h57)};
            else if (b >= 8'h41 && b <= 8'h46)
                hex_acc = {hex_acc[27:0], 4'(b - 8'h37)};
            else
                hex_halt = 1'b1;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, output t_byte_class r);
        cpio_pkg::t_kind kind;
        logic            done;
        kind = seg;
        done = 1'b0;
        case (seg)
            cpio_pkg::K_HEADER: begin
                if (hdr_pos < cpio_pkg::MAGIC_LEN &&
                    b != cpio_pkg::MAGIC_CHARS[hdr_pos[cpio_pkg::MIDX_W-1:0]]) begin
                    seg  = cpio_pkg::K_ERROR;
                    kind = cpio_pkg::K_ERROR;
                end else begin
                    if (hdr_pos >= cpio_pkg::FSIZE_OFS &&
                        hdr_pos < cpio_pkg::FSIZE_OFS + cpio_pkg::HEX_DIGITS) begin
                        take_hex_digit(b, int'(hdr_pos) - cpio_pkg::FSIZE_OFS);
                        if (hdr_pos == cpio_pkg::FSIZE_OFS + cpio_pkg::HEX_DIGITS - 1)
                            fsize_q = hex_acc;
                    end else if (hdr_pos >= cpio_pkg::NSIZE_OFS &&
                                 hdr_pos < cpio_pkg::NSIZE_OFS + cpio_pkg::HEX_DIGITS) begin
                        take_hex_digit(b, int'(hdr_pos) - cpio_pkg::NSIZE_OFS);
                        if (hdr_pos == cpio_pkg::NSIZE_OFS + cpio_pkg::HEX_DIGITS - 1)
                            nsize_q = hex_acc;
                    end
                    hdr_pos = hdr_pos + 7'd1;
                    if (hdr_pos >= cpio_pkg::HDR_LEN)
                        close_segment(cpio_pkg::K_HEADER, done);
                end
            end
            cpio_pkg::K_NAME: begin
                if (trl_idx < cpio_pkg::TRAILER_LEN) begin
                    if (b != cpio_pkg::TRAILER_CHARS[trl_idx])
                        trl_ok = 1'b0;
                    trl_idx = trl_idx + 4'd1;
                end
                left_in_seg = left_in_seg - 32'd1;
                if (left_in_seg == 0)
                    close_segment(cpio_pkg::K_NAME, done);
            end
            cpio_pkg::K_NAMEPAD, cpio_pkg::K_DATA, cpio_pkg::K_DATAPAD: begin
                left_in_seg = left_in_seg - 32'd1;
                if (left_in_seg == 0)
                    close_segment(seg, done);
            end
            cpio_pkg::K_END: begin
            end
            default: begin
                seg  = cpio_pkg::K_ERROR;
                kind = cpio_pkg::K_ERROR;
            end
        endcase
        r.kind    = kind;
        r.data    = b;
        r.fsize   = fsize_q;
        r.nlen    = nsize_q;
        r.done    = done;
        r.trailer = trailer_hit();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg         = cpio_pkg::K_HEADER;
            hdr_pos     = '0;
            hex_acc     = '0;
            hex_halt    = 1'b0;
            fsize_q     = '0;
            nsize_q     = '0;
            left_in_seg = '0;
            trl_ok      = 1'b1;
            trl_idx     = '0;
            classified_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                classify_byte(i_in_byte, new_r);
                classified_q.push_back(new_r);
            end
            if (i_out_valid && i_out_ready) begin
                if (classified_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding, kind",
                                    32'(i_out_kind), 32'(cpio_pkg::K_ERROR));
                end else begin
                    want_r = classified_q.pop_front();
                    if (i_out_kind != want_r.kind)
                        report_mismatch("byte_kind", 32'(i_out_kind), 32'(want_r.kind));
                    if (i_out_data != want_r.data)
                        report_mismatch("data_byte", 32'(i_out_data), 32'(want_r.data));
                    if (i_out_fsize != want_r.fsize)
                        report_mismatch("entry_size", i_out_fsize, want_r.fsize);
                    if (i_out_nlen != want_r.nlen)
                        report_mismatch("name_length", i_out_nlen, want_r.nlen);
                    if (i_out_done != want_r.done)
                        report_mismatch("entry_done", 32'(i_out_done), 32'(want_r.done));
                    if (i_out_trailer != want_r.trailer)
                        report_mismatch("is_trailer", 32'(i_out_trailer),
                                        32'(want_r.trailer));
                end
                n_results++;
            end
        end
        o_pending <= classified_q.size();
    end

endmodule

>>> test/cpio_newc_stream_parser_tb.sv
module cpio_newc_stream_parser_tb;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_BYTES  = 1650;
    localparam int BYTES_PER_MIX = 400;

    // Characters just outside the hex digit ranges
    localparam logic [7:0] HEX_EDGES [6] = '{
        8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67
    };

    typedef enum int {NAME_RANDOM, NAME_TRAILER, NAME_NEAR_MISS} t_name_style;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_archive_byte = 8'h00;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_entry_size;
    logic [31:0] o_name_length;
    logic        o_entry_done;
    logic        o_is_trailer;

    int          pending;
    int          mismatches;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          quiet_cycles  = 0;
    int          bytes_sent    = 0;
    logic [7:0]  stream_q[$];

    always #5 i_clk = ~i_clk;

    cpio_newc_stream_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_archive_byte (i_archive_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte_kind    (o_byte_kind),
        .o_data_byte    (o_data_byte),
        .o_entry_size   (o_entry_size),
        .o_name_length  (o_name_length),
        .o_entry_done   (o_entry_done),
        .o_is_trailer   (o_is_trailer)
    );

    cpio_newc_parse_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_byte     (i_archive_byte),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_kind    (o_byte_kind),
        .i_out_data    (o_data_byte),
        .i_out_fsize   (o_entry_size),
        .i_out_nlen    (o_name_length),
        .i_out_done    (o_entry_done),
        .i_out_trailer (o_is_trailer),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if no item moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_idle_mix(input int mix);
        case (mix % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    task automatic send_stream();
        logic [7:0] b;
        while (stream_q.size() != 0) begin
            b = stream_q.pop_front();
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid        <= 1'b1;
            i_archive_byte <= b;
            @(posedge i_clk);
            while (!o_ready)
                @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    // Eight-character size field: the value in a random number of digits with
    // mixed case; a short field is cut off by a non-hex byte and junk.
    task automatic queue_hex_field(input logic [31:0] value);
        int         needed;
        int         digits;
        int         i;
        logic [3:0] nib;
        logic [7:0] c;
        needed = 0;
        while (needed < 8 && (value >> (4 * needed)) != 0)
            needed++;
        digits = $urandom_range(8, needed);
        for (i = digits - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            if (nib < 4'd10)
                c = 8'h30 + 8'(nib);
            else
                c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
            stream_q.push_back(c);
        end
        if (digits < 8) begin
            if ($urandom_range(2) != 0) begin
                c = HEX_EDGES[$urandom_range(5)];
            end else begin
                c = 8'($urandom_range(255));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66))
                    c = 8'($urandom_range(255));
            end
            stream_q.push_back(c);
            for (i = digits + 1; i < 8; i++)
                stream_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_entry(input int nsize, input int fsize,
                               input t_name_style style, input bit extreme_data);
        int         i;
        int         span;
        int         miss_at;
        logic [7:0] c;
        for (i = 0; i < cpio_pkg::MAGIC_LEN; i++)
            stream_q.push_back(cpio_pkg::MAGIC_CHARS[i]);
        for (i = cpio_pkg::MAGIC_LEN; i < cpio_pkg::FSIZE_OFS; i++)
            stream_q.push_back(8'($urandom_range(255)));
        queue_hex_field(fsize);
        for (i = cpio_pkg::FSIZE_OFS + cpio_pkg::HEX_DIGITS; i < cpio_pkg::NSIZE_OFS; i++)
            stream_q.push_back(8'($urandom_range(255)));
        queue_hex_field(nsize);
        for (i = cpio_pkg::NSIZE_OFS + cpio_pkg::HEX_DIGITS; i < cpio_pkg::HDR_LEN; i++)
            stream_q.push_back(8'($urandom_range(255)));
        span    = (nsize < cpio_pkg::TRAILER_LEN) ? nsize : cpio_pkg::TRAILER_LEN;
        miss_at = (span > 0) ? $urandom_range(span - 1) : 0;
        for (i = 0; i < nsize; i++) begin
            if (style != NAME_RANDOM && i < span) begin
                c = cpio_pkg::TRAILER_CHARS[i];
                // flip one bit so the name just misses the end marker
                if (style == NAME_NEAR_MISS && i == miss_at)
                    c = c ^ (8'd1 << $urandom_range(7));
            end else begin
                c = 8'($urandom_range(255));
            end
            stream_q.push_back(c);
        end
        for (i = 0; i < (4 - (cpio_pkg::HDR_LEN + nsize) % 4) % 4; i++)
            stream_q.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h00);
        for (i = 0; i < fsize; i++)
            stream_q.push_back(extreme_data ? (i[0] ? 8'hFF : 8'h00)
                                            : 8'($urandom_range(255)));
        for (i = 0; i < (4 - fsize % 4) % 4; i++)
            stream_q.push_back(8'h00);
        send_stream();
    endtask

    initial begin
        int          nsize;
        int          fsize;
        int          pick;
        int          bad_at;
        int          i;
        t_name_style style;
        logic [7:0]  w;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty segments, trailer text without its NUL, near misses,
        // extreme data bytes, odd sizes for both paddings
        set_idle_mix(0);
        queue_entry(0, 0, NAME_RANDOM, 1'b0);
        queue_entry(10, 1, NAME_TRAILER, 1'b1);
        queue_entry(11, 4, NAME_NEAR_MISS, 1'b1);
        queue_entry(12, 3, NAME_NEAR_MISS, 1'b1);
        queue_entry(2, 31, NAME_RANDOM, 1'b1);

        while (bytes_sent < RANDOM_BYTES) begin
            set_idle_mix(bytes_sent / BYTES_PER_MIX);
            pick = $urandom_range(99);
            if (pick < 8)
                nsize = 0;
            else if (pick < 22)
                nsize = $urandom_range(12, 9);
            else
                nsize = $urandom_range(24, 1);
            pick = $urandom_range(99);
            if (pick < 10)
                fsize = 0;
            else if (pick < 16)
                fsize = $urandom_range(70, 33);
            else
                fsize = $urandom_range(16, 1);
            pick = $urandom_range(99);
            if (pick < 70)
                style = NAME_RANDOM;
            else if (pick < 85 && nsize < cpio_pkg::TRAILER_LEN)
                style = NAME_TRAILER;
            else
                style = NAME_NEAR_MISS;
            queue_entry(nsize, fsize, style, 1'b0);
        end

        // Both end states hold until reset, so the seed picks which one
        // closes the run: the archive's end marker or a broken magic.
        set_idle_mix(3);
        if ($urandom_range(1) != 0) begin
            queue_entry($urandom_range(14, cpio_pkg::TRAILER_LEN), $urandom_range(9),
                        NAME_TRAILER, 1'b0);
        end else begin
            bad_at = $urandom_range(cpio_pkg::MAGIC_LEN - 1);
            for (i = 0; i < bad_at; i++)
                stream_q.push_back(cpio_pkg::MAGIC_CHARS[i]);
            w = 8'($urandom_range(255));
            while (w == cpio_pkg::MAGIC_CHARS[bad_at])
                w = 8'($urandom_range(255));
            stream_q.push_back(w);
        end
        for (i = 0; i < 24; i++)
            stream_q.push_back(8'($urandom_range(255)));
        send_stream();
        i_valid   <= 1'b0;
        stall_pct  = 0;

        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cpio_pkg.sv
hw/rtl/cpio_newc_stream_parser.sv
test/cpio_newc_parse_checker.sv
test/cpio_newc_stream_parser_tb.sv
